// ===== sv/pfde_pkg.sv =====
// Shared codes, widths and controller/datapath interface types of the draw engine.
package pfde_pkg;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_CHAR  = 3'd1;
  localparam logic [2:0] MODE_HLINE = 3'd2;
  localparam logic [2:0] MODE_VLINE = 3'd3;
  localparam logic [2:0] MODE_LOAD  = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  // First printable character code of the font
  localparam logic [7:0] FIRST_CHAR = 8'd32;

  // Working widths: column (up to x + 254), page, frame address, font address
  localparam int CW  = 9;
  localparam int PW  = 5;
  localparam int AXW = 14;
  localparam int FAW = 13;

  // Register index of invert_glyphs on the configuration port
  localparam logic REG_INVERT = 1'b0;

  typedef struct packed {
    logic start;       // latch a new transaction
    logic sweep_step;  // write zero at the sweep address and advance
    logic font_rd;     // read the current glyph column byte
    logic adv_glyph;   // skip to the next glyph column
    logic adv;         // advance past the current merge target
    logic frame_rd;    // read the frame byte of the current target
    logic frame_wr;    // write back the merged byte
    logic set_bad;     // flag an out-of-range access
    logic rd_cap;      // capture read data for the result
    logic load_out;    // load the result register
  } pfde_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       empty;
    logic       glyph_ok;
    logic       glyph_last;
    logic       tgt_bad;
    logic       tgt_skip;
    logic       last;
    logic       next_font;
    logic       sweep_last;
    logic       out_busy;
  } pfde_stat_t;

endpackage

// ===== sv/page_framebuffer_draw_engine.sv =====
// Top level of the page framebuffer draw engine: ports, config register, controller and datapath.
//
//  channel  | direction | fields
//  ---------+-----------+-------------------------------------------------------
//  in_*     | slave     | tdata: mode, x_start, x_end, y_start, y_end, thickness,
//           |           |        char_code, font_address, font_byte
//  out_*    | master    | tdata: read_data, status
//  cfg_*    | APB       | reg 0 at 0x0: invert_glyphs
//
// One transaction at a time. After reset a clearing pass over all WIDTH*HEIGHT/8 bytes
// runs with in_tready low. A finished result waits in the output register; a stalled
// out_tready holds it.
module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int WIDTH       = 128,
  parameter int HEIGHT      = 64,
  parameter int GLYPH_WIDTH = 6,
  parameter int FONT_DEPTH  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] mode, [9:3] x_start, [16:10] x_end, [22:17] y_start, [28:23] y_end,
  // [36:29] thickness, [44:37] char_code, [54:45] font_address, [62:55] font_byte
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] status
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pfde_cmd_t  cmd;
  pfde_stat_t st;
  logic       invert_r;

  // Configuration register
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_INVERT)) begin
      invert_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_INVERT) ? {31'd0, invert_r} : 32'd0;

  pfde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid && in_tready),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pfde_dp #(
    .WIDTH       (WIDTH),
    .HEIGHT      (HEIGHT),
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .FONT_DEPTH  (FONT_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .invert       (invert_r),
    .mode         (in_tdata[2:0]),
    .x_start      (in_tdata[9:3]),
    .x_end        (in_tdata[16:10]),
    .y_start      (in_tdata[22:17]),
    .y_end        (in_tdata[28:23]),
    .thickness    (in_tdata[36:29]),
    .char_code    (in_tdata[44:37]),
    .font_address (in_tdata[54:45]),
    .font_byte    (in_tdata[62:55]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_data     (out_tdata)
  );

endmodule

// ===== sv/pfde_ctrl.sv =====
// Sequencing state machine of the draw engine.
module pfde_ctrl
  import pfde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  output logic       in_ready,
  input  pfde_stat_t st,
  output pfde_cmd_t  cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_FONT  = 3'd4;
  localparam logic [2:0] S_MCHK  = 3'd5;
  localparam logic [2:0] S_MWR   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] after_adv;

  assign in_ready = (state_r == S_IDLE);

  // Pick the step that follows an advance
  always_comb begin
    if (st.last) begin
      after_adv = S_DONE;
    end else if (st.next_font) begin
      after_adv = S_FONT;
    end else begin
      after_adv = S_MCHK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.mode)
          MODE_CLEAR: state_nxt = S_SWEEP;
          MODE_CHAR:  state_nxt = S_FONT;
          MODE_HLINE, MODE_VLINE: state_nxt = st.empty ? S_DONE : S_MCHK;
          MODE_READ:  state_nxt = S_MCHK;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) state_nxt = S_DONE;
      end
      S_FONT: begin
        if (st.glyph_ok) begin
          cmd.font_rd = 1'b1;
          state_nxt   = S_MCHK;
        end else begin
          cmd.set_bad   = 1'b1;
          cmd.adv_glyph = 1'b1;
          state_nxt     = st.glyph_last ? S_DONE : S_FONT;
        end
      end
      S_MCHK: begin
        // An empty row mask touches nothing, so it never counts as out of range
        if (st.tgt_skip) begin
          cmd.adv   = 1'b1;
          state_nxt = after_adv;
        end else if (st.tgt_bad) begin
          cmd.set_bad = 1'b1;
          if (st.mode == MODE_READ) begin
            state_nxt = S_DONE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = after_adv;
          end
        end else begin
          cmd.frame_rd = 1'b1;
          state_nxt    = S_MWR;
        end
      end
      S_MWR: begin
        if (st.mode == MODE_READ) begin
          cmd.rd_cap = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.frame_wr = 1'b1;
          cmd.adv      = 1'b1;
          state_nxt    = after_adv;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/pfde_dp.sv =====
// Datapath of the draw engine: stores, iteration counters, merge logic, result register.
module pfde_dp
  import pfde_pkg::*;
#(
  parameter int WIDTH       = 128,
  parameter int HEIGHT      = 64,
  parameter int GLYPH_WIDTH = 6,
  parameter int FONT_DEPTH  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pfde_cmd_t   cmd,
  output pfde_stat_t  st,
  input  logic        invert,
  input  logic [2:0]  mode,
  input  logic [6:0]  x_start,
  input  logic [6:0]  x_end,
  input  logic [5:0]  y_start,
  input  logic [5:0]  y_end,
  input  logic [7:0]  thickness,
  input  logic [7:0]  char_code,
  input  logic [9:0]  font_address,
  input  logic [7:0]  font_byte,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] out_data
);

  localparam int PAGES = HEIGHT / 8;
  localparam int FB    = WIDTH * PAGES;
  localparam int AW    = $clog2(FB);
  localparam int FIW   = $clog2(FONT_DEPTH);
  localparam int GIW   = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

  logic [7:0] frame_mem [FB];
  logic [7:0] font_mem  [FONT_DEPTH];

  logic [2:0]     mode_r;
  logic [6:0]     xs_r, xe_r;
  logic [5:0]     ys_r, ye_r;
  logic [7:0]     th_r, code_r;
  logic [CW-1:0]  col_r;
  logic           k_r;
  logic [GIW-1:0] gi_r;
  logic [7:0]     cnt_r;
  logic [6:0]     segy_r;
  logic [FAW-1:0] fa_r;
  logic [AW-1:0]  sweep_r;
  logic           bad_r;
  logic [7:0]     rd_r;
  logic [7:0]     font_q_r;
  logic [7:0]     fq_r;
  logic           out_valid_r;
  logic [15:0]    out_data_r;

  logic [2:0]     down;
  logic [PW-1:0]  page0, page;
  logic [7:0]     glyph;
  logic [15:0]    gw16, gm16, hw16, vw16;
  logic [3:0]     rows;
  logic [8:0]     rmask;
  logic [2:0]     off;
  logic [6:0]     span;
  logic [3:0]     room, len;
  logic [8:0]     lmask;
  logic [7:0]     clr, set;
  logic [AXW-1:0] addr_full;
  logic [AW-1:0]  addr;
  logic [FAW-1:0] fadr_ext;
  logic           col_end, cnt_end, seg_end;

  assign down  = ys_r[2:0];
  assign page0 = PW'(ys_r[5:3]);
  assign glyph = font_q_r ^ {8{invert}};

  // Glyph column shifted into its two pages
  assign gw16 = {8'h00, glyph} << down;
  assign gm16 = 16'h00ff << down;

  // Horizontal line row mask, rows saturated at eight
  assign rows  = (th_r > 8'd8) ? 4'd8 : th_r[3:0];
  assign rmask = (9'd1 << rows) - 9'd1;
  assign hw16  = {8'h00, rmask[7:0]} << down;

  // Vertical line segment up to the page boundary
  assign off   = segy_r[2:0];
  assign span  = {1'b0, ye_r} - segy_r + 7'd1;
  assign room  = 4'd8 - {1'b0, off};
  assign len   = (span > {3'b000, room}) ? room : span[3:0];
  assign lmask = (9'd1 << len) - 9'd1;
  assign vw16  = {8'h00, lmask[7:0]} << off;

  assign col_end = (col_r == CW'(xe_r));
  assign cnt_end = (cnt_r == th_r - 8'd1);
  assign seg_end = ({1'b0, segy_r} + {4'b0000, len}) > {2'b00, ye_r};

  // Select the current merge target
  always_comb begin
    page = page0;
    clr  = 8'h00;
    set  = 8'h00;
    case (mode_r)
      MODE_CHAR: begin
        page = page0 + PW'(k_r);
        clr  = k_r ? gm16[15:8] : gm16[7:0];
        set  = k_r ? gw16[15:8] : gw16[7:0];
      end
      MODE_HLINE: begin
        page = page0 + PW'(k_r);
        clr  = k_r ? hw16[15:8] : hw16[7:0];
        set  = clr;
      end
      MODE_VLINE: begin
        page = PW'(segy_r[5:3]);
        clr  = vw16[7:0];
        set  = vw16[7:0];
      end
      default: begin
        page = page0;
      end
    endcase
  end

  assign addr_full = AXW'(page) * AXW'(WIDTH) + AXW'(col_r);
  assign addr      = addr_full[AW-1:0];
  assign fadr_ext  = FAW'(font_address);

  // Status to the controller
  always_comb begin
    st            = '0;
    st.mode       = mode_r;
    st.empty      = (mode_r == MODE_HLINE) ? (xe_r < xs_r)
                                           : ((ye_r < ys_r) || (th_r == 8'd0));
    st.glyph_ok   = (code_r >= FIRST_CHAR) && (fa_r < FAW'(FONT_DEPTH));
    st.glyph_last = (gi_r == GIW'(GLYPH_WIDTH - 1));
    st.tgt_bad    = (col_r >= CW'(WIDTH)) || (page >= PW'(PAGES));
    st.tgt_skip   = (mode_r == MODE_HLINE) && (set == 8'h00);
    st.sweep_last = (sweep_r == AW'(FB - 1));
    st.out_busy   = out_valid_r && !out_ready;
    st.next_font  = (mode_r == MODE_CHAR) && (k_r || (down == 3'd0));
    case (mode_r)
      MODE_CHAR:  st.last = st.glyph_last && (k_r || (down == 3'd0));
      MODE_HLINE: st.last = col_end && k_r;
      MODE_VLINE: st.last = cnt_end && seg_end;
      default:    st.last = 1'b1;
    endcase
  end

  // Frame store: one shared write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      frame_mem[sweep_r] <= 8'h00;
    end else if (cmd.frame_wr) begin
      frame_mem[addr] <= (fq_r & ~clr) | set;
    end
    if (cmd.frame_rd) begin
      fq_r <= frame_mem[addr];
    end
  end

  // Font store: loaded on accept, registered read
  always_ff @(posedge clk) begin
    if (cmd.start && (mode == MODE_LOAD) && (fadr_ext < FAW'(FONT_DEPTH))) begin
      font_mem[fadr_ext[FIW-1:0]] <= font_byte;
    end
    if (cmd.font_rd) begin
      font_q_r <= font_mem[fa_r[FIW-1:0]];
    end
  end

  // Transaction fields and iteration counters
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= mode;
      xs_r   <= x_start;
      xe_r   <= x_end;
      ys_r   <= y_start;
      ye_r   <= y_end;
      th_r   <= thickness;
      code_r <= char_code;
      col_r  <= CW'(x_start);
      k_r    <= 1'b0;
      gi_r   <= '0;
      cnt_r  <= 8'd0;
      segy_r <= {1'b0, y_start};
      fa_r   <= (FAW'(char_code) - FAW'(FIRST_CHAR)) * FAW'(GLYPH_WIDTH);
      bad_r  <= (mode == MODE_LOAD) && (fadr_ext >= FAW'(FONT_DEPTH));
      rd_r   <= 8'h00;
    end else begin
      if (cmd.set_bad) bad_r <= 1'b1;
      if (cmd.rd_cap) rd_r <= fq_r;
      if (cmd.adv_glyph) begin
        k_r   <= 1'b0;
        gi_r  <= gi_r + GIW'(1);
        fa_r  <= fa_r + FAW'(1);
        col_r <= col_r + CW'(1);
      end else if (cmd.adv) begin
        case (mode_r)
          MODE_CHAR: begin
            if (k_r || (down == 3'd0)) begin
              k_r   <= 1'b0;
              gi_r  <= gi_r + GIW'(1);
              fa_r  <= fa_r + FAW'(1);
              col_r <= col_r + CW'(1);
            end else begin
              k_r <= 1'b1;
            end
          end
          MODE_HLINE: begin
            if (col_end) begin
              k_r   <= 1'b1;
              col_r <= CW'(xs_r);
            end else begin
              col_r <= col_r + CW'(1);
            end
          end
          MODE_VLINE: begin
            if (cnt_end) begin
              cnt_r  <= 8'd0;
              col_r  <= CW'(xs_r);
              segy_r <= segy_r + {3'b000, len};
            end else begin
              cnt_r <= cnt_r + 8'd1;
              col_r <= col_r + CW'(1);
            end
          end
          default: begin
            k_r <= k_r;
          end
        endcase
      end
    end
  end

  // Sweep address for clear and the pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_r <= st.sweep_last ? '0 : sweep_r + AW'(1);
    end
  end

  // Result register: holds until the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {7'b0000000, bad_r, rd_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the page framebuffer draw engine.
`timescale 1ns / 1ps

module tb;
  import pfde_pkg::*;

  localparam int FB_W     = 128;
  localparam int FB_PAGES = 8;
  localparam int GW       = 6;
  localparam int FDEPTH   = 1024;
  localparam logic [2:0] ADDR_INVERT = 3'd0;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] xs;
    logic [6:0] xe;
    logic [5:0] ys;
    logic [5:0] ye;
    logic [7:0] th;
    logic [7:0] code;
    logic [9:0] fadr;
    logic [7:0] fbyte;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       bad;
  } draw_res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [63:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [15:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  page_framebuffer_draw_engine DUT (.*);

  // Predictor state
  logic [7:0] frame_mdl [FB_W*FB_PAGES];
  logic [7:0] font_mdl [FDEPTH];
  bit         font_written [FDEPTH];
  logic       invert_mdl;
  draw_res_t  expected_q[$];
  int         errors, results_seen, items_sent;
  bit         stall_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
  endtask

  function automatic void merge(input int col, input int page, input logic [7:0] clr,
                                input logic [7:0] set, inout bit bad);
    if (col >= FB_W || page >= FB_PAGES) begin
      bad = 1;
      return;
    end
    frame_mdl[page*FB_W+col] = (frame_mdl[page*FB_W+col] & ~clr) | set;
  endfunction

  function automatic draw_res_t predict_draw(input draw_cmd_t c);
    draw_res_t r;
    bit bad;
    int fa, dn, rows, y, len, off;
    logic [7:0] g, bits;
    logic [15:0] wide;
    bad = 0;
    r.rd = 0;
    case (c.mode)
      MODE_CLEAR: for (int a = 0; a < FB_W*FB_PAGES; a++) frame_mdl[a] = 0;
      MODE_CHAR: begin
        dn = c.ys & 7;
        for (int i = 0; i < GW; i++) begin
          if (c.code < FIRST_CHAR) begin bad = 1; continue; end
          fa = (c.code - FIRST_CHAR) * GW + i;
          if (fa >= FDEPTH) begin bad = 1; continue; end
          g = font_mdl[fa];
          if (invert_mdl) g = ~g;
          merge(c.xs + i, c.ys >> 3, 8'hff << dn, g << dn, bad);
          if (dn != 0)
            merge(c.xs + i, (c.ys >> 3) + 1, 8'hff >> (8 - dn), g >> (8 - dn), bad);
        end
      end
      MODE_HLINE: begin
        rows = c.th > 8 ? 8 : c.th;
        wide = ((16'd1 << rows) - 1) << (c.ys & 7);
        for (int k = 0; k < 2; k++) begin
          bits = wide >> (8*k);
          if (bits == 0) continue;
          for (int x = c.xs; x <= c.xe; x++) merge(x, (c.ys >> 3) + k, bits, bits, bad);
        end
      end
      MODE_VLINE: begin
        y = c.ys;
        while (y <= c.ye) begin
          off = y & 7;
          len = c.ye - y + 1;
          if (len > 8 - off) len = 8 - off;
          bits = ((9'd1 << len) - 1) << off;
          for (int i = 0; i < c.th; i++) merge(c.xs + i, y >> 3, bits, bits, bad);
          y += len;
        end
      end
      MODE_LOAD: begin
        font_mdl[c.fadr] = c.fbyte;
        font_written[c.fadr] = 1;
      end
      MODE_READ: r.rd = frame_mdl[(c.ys >> 3)*FB_W + c.xs];
      default: ;
    endcase
    r.bad = bad;
    return r;
  endfunction

  // Send one command; bursts with random gaps between them
  int burst_left;
  task automatic send_cmd(input draw_cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    burst_left--;
    expected_q.push_back(predict_draw(c));
    in_tvalid <= 1;
    in_tdata <= {1'b0, c.fbyte, c.fadr, c.code, c.th, c.ye, c.ys, c.xe, c.xs, c.mode};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 0;
    // leave the drop in its own cycle
    @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_invert(input logic v);
    drain();
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= ADDR_INVERT; cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    invert_mdl = v;
  endtask

  // Result checker with its own stall pattern
  always @(posedge clk) begin
    draw_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) report("unexpected result", out_tdata, 0);
        else begin
          want = expected_q.pop_front();
          if (out_tdata[7:0] !== want.rd) report("read_data", out_tdata[7:0], want.rd);
          if (out_tdata[8] !== want.bad) report("status", out_tdata[8], want.bad);
          if (out_tdata[15:9] !== 7'd0) report("pad", out_tdata[15:9], 0);
        end
        results_seen++;
      end
      if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
      out_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  function automatic draw_cmd_t rand_cmd(input int mode);
    draw_cmd_t c;
    c = 63'({$urandom, $urandom});
    c.mode = 3'(mode);
    if ($urandom_range(0, 3) != 0) c.th = 8'($urandom_range(0, 10));
    if (mode == MODE_CHAR) begin
      c.code = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(32, 80));
      // unloaded font entries are never read
      for (int i = 0; i < GW; i++) begin
        int fa;
        fa = (int'(c.code) - 32) * GW + i;
        if (c.code >= 32 && fa < FDEPTH && !font_written[fa]) c.code = 8'd0;
      end
    end
    return c;
  endfunction

  task automatic test_directed();
    draw_cmd_t c;
    c = '0;
    c.mode = MODE_READ; send_cmd(c);
    c.xs = 127; c.ys = 63; send_cmd(c);
    // load the first glyphs, all-ones font bytes too
    for (int a = 0; a < 12; a++) begin
      c = '0; c.mode = MODE_LOAD; c.fadr = 10'(a);
      c.fbyte = a[0] ? 8'hff : 8'h5a ^ 8'(a);
      send_cmd(c);
    end
    c = '0; c.mode = MODE_CHAR; c.code = 33; c.xs = 125; c.ys = 61; send_cmd(c);
    c.code = 5; c.xs = 0; c.ys = 0; send_cmd(c);
    c.code = 255; send_cmd(c);
    c = '0; c.mode = MODE_HLINE; c.xs = 120; c.xe = 127; c.ys = 60; c.th = 128; send_cmd(c);
    c.xs = 10; c.xe = 5; send_cmd(c);
    c.xs = 0; c.xe = 0; c.th = 0; send_cmd(c);
    c = '0; c.mode = MODE_VLINE; c.xs = 126; c.ys = 3; c.ye = 63; c.th = 4; send_cmd(c);
    c.ys = 10; c.ye = 9; send_cmd(c);
    c.mode = 3'd6; send_cmd(c);
    c.mode = 3'd7; send_cmd(c);
    c = '0; c.mode = MODE_LOAD; c.fadr = 10'h3ff; c.fbyte = 8'hff; send_cmd(c);
    c = '0; c.mode = MODE_CLEAR; send_cmd(c);
  endtask

  task automatic test_font_fill();
    draw_cmd_t c;
    for (int a = 0; a < 300; a++) begin
      c = rand_cmd(MODE_LOAD); c.fadr = 10'(a); send_cmd(c);
    end
  endtask

  task automatic test_random(input int n);
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 99);
      if (m < 2) m = MODE_CLEAR;
      else if (m < 22) m = MODE_CHAR;
      else if (m < 40) m = MODE_HLINE;
      else if (m < 58) m = MODE_VLINE;
      else if (m < 68) m = MODE_LOAD;
      else if (m < 97) m = MODE_READ;
      else m = $urandom_range(6, 7);
      send_cmd(rand_cmd(m));
      // pause once until everything has come back
      if (i == n/2) while (expected_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; results_seen = 0; items_sent = 0; burst_left = 0; stall_on = 0;
    invert_mdl = 0;
    for (int a = 0; a < FB_W*FB_PAGES; a++) frame_mdl[a] = 0;
    for (int a = 0; a < FDEPTH; a++) begin font_mdl[a] = 0; font_written[a] = 0; end
    repeat (7) @(posedge clk);
    rst_n <= 1;
    test_directed();
    write_invert(1);
    test_directed();
    test_font_fill();
    write_invert(0);
    test_random(600);
    write_invert(1);
    test_random(400);
    write_invert(0);
    test_random(250);
    drain();
    $display("sent %0d draw commands, checked %0d results", items_sent, results_seen);
    $display("covered all modes, both glyph inversion settings and off-buffer writes");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
